>>> hdl/cmsd_pkg.sv
// ----------------------------------------------------------------------------
// cmsd_pkg : shared constants and tables of the color marker spiral decoder
// Grid sizes, symbol codes, center cell addresses and the spiral walk table.
// ----------------------------------------------------------------------------
package cmsd_pkg;

    localparam int CHROMA_WIDTH_DEF = 16;
    localparam int GRID_SIDE        = 6;
    localparam int GRID_LAST        = 5;
    localparam int GRID_CELLS       = 36;
    localparam int ADDR_W           = $clog2(GRID_CELLS);
    localparam int REF_SYMS         = 4;
    localparam int DATA_SYMS        = 32;
    localparam int MARKER_W         = 2 * DATA_SYMS;

    typedef logic [1:0]        t_sym;
    typedef logic [1:0]        t_rot;
    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_sym SYM_RED    = 2'd0;
    localparam t_sym SYM_GREEN  = 2'd1;
    localparam t_sym SYM_YELLOW = 2'd2;
    localparam t_sym SYM_BLUE   = 2'd3;

    localparam t_rot ROT_0   = 2'd0;
    localparam t_rot ROT_90  = 2'd1;
    localparam t_rot ROT_180 = 2'd2;
    localparam t_rot ROT_270 = 2'd3;

    // center cells, slot order: 14, 15, 20, 21
    localparam t_addr CELL_14 = 6'd14;
    localparam t_addr CELL_15 = 6'd15;
    localparam t_addr CELL_20 = 6'd20;
    localparam t_addr CELL_21 = 6'd21;

    function automatic t_addr ctr_addr(input logic [1:0] slot);
        t_addr a;
        case (slot)
            2'd0:    a = CELL_14;
            2'd1:    a = CELL_15;
            2'd2:    a = CELL_20;
            default: a = CELL_21;
        endcase
        return a;
    endfunction

    // center slot holding the reference of a color (red, green, yellow, blue)
    function automatic logic [1:0] ref_slot(input t_rot rot, input t_sym color);
        logic [7:0] map;
        case (rot)
            ROT_0:   map = {2'd0, 2'd1, 2'd3, 2'd2};
            ROT_90:  map = {2'd1, 2'd3, 2'd2, 2'd0};
            ROT_180: map = {2'd3, 2'd2, 2'd0, 2'd1};
            default: map = {2'd2, 2'd0, 2'd1, 2'd3};
        endcase
        return map[2*color +: 2];
    endfunction

    // unrotated spiral: {row, col} of step k
    function automatic logic [5:0] spiral_rc(input logic [5:0] k);
        logic [5:0] rc;
        case (k)
            6'd0:  rc = {3'd2, 3'd2};
            6'd1:  rc = {3'd2, 3'd3};
            6'd2:  rc = {3'd3, 3'd3};
            6'd3:  rc = {3'd3, 3'd2};
            6'd4:  rc = {3'd3, 3'd1};
            6'd5:  rc = {3'd2, 3'd1};
            6'd6:  rc = {3'd1, 3'd1};
            6'd7:  rc = {3'd1, 3'd2};
            6'd8:  rc = {3'd1, 3'd3};
            6'd9:  rc = {3'd1, 3'd4};
            6'd10: rc = {3'd2, 3'd4};
            6'd11: rc = {3'd3, 3'd4};
            6'd12: rc = {3'd4, 3'd4};
            6'd13: rc = {3'd4, 3'd3};
            6'd14: rc = {3'd4, 3'd2};
            6'd15: rc = {3'd4, 3'd1};
            6'd16: rc = {3'd4, 3'd0};
            6'd17: rc = {3'd3, 3'd0};
            6'd18: rc = {3'd2, 3'd0};
            6'd19: rc = {3'd1, 3'd0};
            6'd20: rc = {3'd0, 3'd0};
            6'd21: rc = {3'd0, 3'd1};
            6'd22: rc = {3'd0, 3'd2};
            6'd23: rc = {3'd0, 3'd3};
            6'd24: rc = {3'd0, 3'd4};
            6'd25: rc = {3'd0, 3'd5};
            6'd26: rc = {3'd1, 3'd5};
            6'd27: rc = {3'd2, 3'd5};
            6'd28: rc = {3'd3, 3'd5};
            6'd29: rc = {3'd4, 3'd5};
            6'd30: rc = {3'd5, 3'd5};
            6'd31: rc = {3'd5, 3'd4};
            6'd32: rc = {3'd5, 3'd3};
            6'd33: rc = {3'd5, 3'd2};
            6'd34: rc = {3'd5, 3'd1};
            default: rc = {3'd5, 3'd0};
        endcase
        return rc;
    endfunction

    // cell address of step k of the spiral under rotation rot
    function automatic t_addr spiral_addr(input t_rot rot, input logic [5:0] k);
        logic [5:0] rc;
        logic [2:0] r0;
        logic [2:0] c0;
        logic [2:0] r;
        logic [2:0] c;
        rc = spiral_rc(k);
        r0 = rc[5:3];
        c0 = rc[2:0];
        case (rot)
            ROT_0: begin
                r = r0;
                c = c0;
            end
            ROT_90: begin
                r = c0;
                c = 3'(GRID_LAST) - r0;
            end
            ROT_180: begin
                r = 3'(GRID_LAST) - r0;
                c = 3'(GRID_LAST) - c0;
            end
            default: begin
                r = 3'(GRID_LAST) - c0;
                c = r0;
            end
        endcase
        return ADDR_W'({3'd0, r} * 6'(GRID_SIDE)) + ADDR_W'({3'd0, c});
    endfunction

endpackage

>>> hdl/cmsd_cell_if.sv
// ----------------------------------------------------------------------------
// cmsd_cell_if : cell input channel
// One beat carries the position and chroma of one marker cell.
// ----------------------------------------------------------------------------
interface cmsd_cell_if #(
    parameter int CW = 16
);
    logic                 valid;
    logic                 ready;
    logic [5:0]           cell_number;
    logic signed [CW-1:0] chroma_a;
    logic signed [CW-1:0] chroma_b;
    logic                 final_cell;

    modport source (output valid, output cell_number, output chroma_a,
                    output chroma_b, output final_cell, input ready);
    modport sink   (input valid, input cell_number, input chroma_a,
                    input chroma_b, input final_cell, output ready);
endinterface

>>> hdl/cmsd_res_if.sv
// ----------------------------------------------------------------------------
// cmsd_res_if : decoded marker output channel
// One beat carries the 64 data bits and the orientation of one marker.
// ----------------------------------------------------------------------------
interface cmsd_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] marker_bits;
    logic [1:0]  orientation;

    modport source (output valid, output marker_bits, output orientation,
                    input ready);
    modport sink   (input valid, input marker_bits, input orientation,
                    output ready);
endinterface

>>> hdl/color_marker_spiral_decoder.sv
// ----------------------------------------------------------------------------
// color_marker_spiral_decoder : 6x6 color marker decoder
// Loads cell chroma into a memory, then walks the rotated spiral and
// classifies each cell against the four center references.
//
// i_cell takes one cell per beat, one beat per cycle, while the block loads.
// A cell number of 36 or more stores nothing. A beat with final_cell set
// is stored and then starts the decode; i_cell.ready stays low until the
// decode is done. The decode reads the four center cells, fixes the
// rotation and reads the 32 data cells through the single read port of the
// cell memory into a four stage classifier; the result appears at o_res in
// the same cycle in which i_cell is ready again.
// o_res holds marker_bits and orientation in an output register. Loading of
// the next marker goes on while a result waits; a decode that finishes
// before o_res.ready has taken the old result waits for it.
// Reset clears the control state and the output valid; memory contents
// stay undefined until written.
// ----------------------------------------------------------------------------
module color_marker_spiral_decoder #(
    parameter int CHROMA_WIDTH = cmsd_pkg::CHROMA_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cmsd_cell_if.sink    i_cell,
    cmsd_res_if.source   o_res
);
    import cmsd_pkg::*;

    localparam int CW = CHROMA_WIDTH;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_REF   = 3'd1;
    localparam logic [2:0] S_RWAIT = 3'd2;
    localparam logic [2:0] S_ROT   = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [5:0]            r_cnt;
    logic [5:0]            n_cnt;
    logic [4:0]            r_nsym;
    logic [4:0]            n_nsym;
    logic                  r_rd_ctr;
    logic [1:0]            r_rd_tag;
    logic                  r_rd_walk;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_rot                  r_rot;
    t_rot                  n_rot;
    logic [MARKER_W-1:0]   r_bits;
    logic [MARKER_W-1:0]   r_out_bits;
    t_rot                  r_out_rot;
    logic signed [CW-1:0]  r_ctr_a [4];
    logic signed [CW-1:0]  r_ctr_b [4];
    logic signed [CW-1:0]  ref_a   [4];
    logic signed [CW-1:0]  ref_b   [4];

    logic                  accept;
    logic                  mem_we;
    t_addr                 mem_raddr;
    logic [2*CW-1:0]       mem_rdata;
    logic                  sym_valid;
    t_sym                  sym;
    logic                  load_out;

    assign accept = i_cell.valid && i_cell.ready;
    assign mem_we = accept && (i_cell.cell_number < 6'(GRID_CELLS));

    cmsd_store #(.CW(CW)) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (i_cell.cell_number),
        .i_wdata ({i_cell.chroma_a, i_cell.chroma_b}),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            ref_a[c] = r_ctr_a[ref_slot(r_rot, 2'(c))];
            ref_b[c] = r_ctr_b[ref_slot(r_rot, 2'(c))];
        end
    end

    cmsd_classify #(.CW(CW)) u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_walk),
        .i_a     (mem_rdata[2*CW-1:CW]),
        .i_b     (mem_rdata[CW-1:0]),
        .i_ref_a (ref_a),
        .i_ref_b (ref_b),
        .o_valid (sym_valid),
        .o_sym   (sym)
    );

    always_comb begin
        logic signed [CW-1:0] b14;
        logic signed [CW-1:0] b15;
        logic signed [CW-1:0] b20;
        logic signed [CW-1:0] b21;
        b14 = r_ctr_b[0];
        b15 = r_ctr_b[1];
        b20 = r_ctr_b[2];
        b21 = r_ctr_b[3];
        if (b15 >= b14 && b15 >= b21 && b15 >= b20) begin
            n_rot = ROT_0;
        end else if (b21 >= b14 && b21 >= b15 && b21 >= b20) begin
            n_rot = ROT_90;
        end else if (b20 >= b14 && b20 >= b21 && b20 >= b15) begin
            n_rot = ROT_180;
        end else begin
            n_rot = ROT_270;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_nsym    = r_nsym;
        mem_raddr = ctr_addr(r_cnt[1:0]);
        load_out  = 1'b0;
        if (sym_valid) begin
            n_nsym = r_nsym + 5'd1;
        end
        case (r_state)
            S_LOAD: begin
                if (accept && i_cell.final_cell) begin
                    n_state = S_REF;
                    n_cnt   = '0;
                    n_nsym  = '0;
                end
            end
            S_REF: begin
                n_cnt = r_cnt + 6'd1;
                if (r_cnt[1:0] == 2'd3) begin
                    n_state = S_RWAIT;
                end
            end
            S_RWAIT: begin
                n_state = S_ROT;
            end
            S_ROT: begin
                n_cnt   = 6'(REF_SYMS);
                n_state = S_WALK;
            end
            S_WALK: begin
                mem_raddr = spiral_addr(r_rot, r_cnt);
                n_cnt     = r_cnt + 6'd1;
                if (r_cnt == 6'(GRID_CELLS - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (sym_valid && r_nsym == 5'(DATA_SYMS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    load_out = 1'b1;
                    n_state  = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
        if (load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_nsym      <= '0;
            r_rd_ctr    <= 1'b0;
            r_rd_tag    <= '0;
            r_rd_walk   <= 1'b0;
            r_out_valid <= 1'b0;
            r_rot       <= ROT_0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_nsym      <= n_nsym;
            r_rd_ctr    <= (r_state == S_REF);
            r_rd_tag    <= r_cnt[1:0];
            r_rd_walk   <= (r_state == S_WALK);
            r_out_valid <= n_out_valid;
            if (r_state == S_ROT) begin
                r_rot <= n_rot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_ctr) begin
            r_ctr_a[r_rd_tag] <= mem_rdata[2*CW-1:CW];
            r_ctr_b[r_rd_tag] <= mem_rdata[CW-1:0];
        end
        if (sym_valid) begin
            r_bits <= {r_bits[MARKER_W-3:0], sym};
        end
        if (load_out) begin
            r_out_bits <= r_bits;
            r_out_rot  <= r_rot;
        end
    end

    assign i_cell.ready      = (r_state == S_LOAD);
    assign o_res.valid       = r_out_valid;
    assign o_res.marker_bits = r_out_bits;
    assign o_res.orientation = r_out_rot;

endmodule

>>> hdl/cmsd_store.sv
// ----------------------------------------------------------------------------
// cmsd_store : cell chroma memory
// 36 entries of {a, b}, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cmsd_store #(
    parameter int CW = 16
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  cmsd_pkg::t_addr         i_waddr,
    input  logic [2*CW-1:0]         i_wdata,
    input  cmsd_pkg::t_addr         i_raddr,
    output logic [2*CW-1:0]         o_rdata
);
    import cmsd_pkg::*;

    logic [2*CW-1:0] r_mem [GRID_CELLS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> hdl/cmsd_classify.sv
// ----------------------------------------------------------------------------
// cmsd_classify : nearest reference classifier
// Four stage pipeline: abs differences, squares, distance sums, decision.
// ----------------------------------------------------------------------------
module cmsd_classify #(
    parameter int CW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [CW-1:0] i_a,
    input  logic signed [CW-1:0] i_b,
    input  logic signed [CW-1:0] i_ref_a [4],
    input  logic signed [CW-1:0] i_ref_b [4],
    output logic                 o_valid,
    output cmsd_pkg::t_sym       o_sym
);
    import cmsd_pkg::*;

    localparam int DW = 2 * CW + 1;

    logic [CW-1:0]   r_abs  [8];
    logic [2*CW-1:0] r_sq   [8];
    logic [DW-1:0]   r_dist [4];
    logic [2:0]      r_vld;
    logic [2:0]      n_vld;
    logic [CW-1:0]   n_abs  [8];
    t_sym            n_sym;

    always_comb begin
        logic signed [CW:0] da;
        logic signed [CW:0] db;
        logic [CW:0]        ua;
        logic [CW:0]        ub;
        for (int k = 0; k < 4; k++) begin
            da = (CW+1)'(i_a) - (CW+1)'(i_ref_a[k]);
            db = (CW+1)'(i_b) - (CW+1)'(i_ref_b[k]);
            ua = da[CW] ? (CW+1)'(-da) : da;
            ub = db[CW] ? (CW+1)'(-db) : db;
            n_abs[2*k]   = ua[CW-1:0];
            n_abs[2*k+1] = ub[CW-1:0];
        end
    end

    // distances in color order: red, green, yellow, blue
    always_comb begin
        logic [DW-1:0] rd;
        logic [DW-1:0] gd;
        logic [DW-1:0] yd;
        logic [DW-1:0] bd;
        rd = r_dist[0];
        gd = r_dist[1];
        yd = r_dist[2];
        bd = r_dist[3];
        if (gd <= rd && gd <= yd && gd <= bd) begin
            n_sym = SYM_GREEN;
        end else if (bd <= rd && bd <= yd && bd <= gd) begin
            n_sym = SYM_BLUE;
        end else if (rd <= bd && rd <= yd && rd <= gd) begin
            n_sym = SYM_RED;
        end else begin
            n_sym = SYM_YELLOW;
        end
    end

    assign n_vld = {r_vld[1:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_vld   <= n_vld;
            o_valid <= r_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 8; j++) begin
            r_abs[j] <= n_abs[j];
            r_sq[j]  <= (2*CW)'(r_abs[j]) * (2*CW)'(r_abs[j]);
        end
        for (int k = 0; k < 4; k++) begin
            r_dist[k] <= DW'(r_sq[2*k]) + DW'(r_sq[2*k+1]);
        end
        o_sym <= n_sym;
    end

endmodule

>>> hdl/cmsd_chk.sv
// ----------------------------------------------------------------------------
// cmsd_chk : port checker of the color marker spiral decoder
// Watches the cell and result channels at the top level ports.
// ----------------------------------------------------------------------------
module cmsd_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cell_valid,
    input logic        i_cell_ready,
    input logic        i_cell_final,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [63:0] i_res_bits,
    input logic [1:0]  i_res_orient
);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_res_bits) && $stable(i_res_orient))
        else $error("result beat changed while stalled");

    a_final_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cell_valid && i_cell_ready && i_cell_final |=>
            !i_cell_ready ##8 !i_cell_ready)
        else $error("cell beat taken during decode");

    a_result_after_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(!i_cell_ready))
        else $error("result appeared without a decode");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

endmodule

bind color_marker_spiral_decoder cmsd_chk u_cmsd_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cell_valid (i_cell.valid),
    .i_cell_ready (i_cell.ready),
    .i_cell_final (i_cell.final_cell),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_bits   (o_res.marker_bits),
    .i_res_orient (o_res.orientation)
);
